/* hw/rtl/stpc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpc_pkg: shared constants, types and sine table for the three-phase
// PWM compare unit.
// ----------------------------------------------------------------------------
package stpc_pkg;

  // table and scaling
  localparam int unsigned TABLE_ENTRIES = 360;
  localparam int unsigned SINE_SCALE    = 10000;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned PHASE_STEP    = TABLE_ENTRIES / 3;
  localparam int unsigned SINE_W        = 16;

  // field widths
  localparam int unsigned AXIS_W   = 2;
  localparam int unsigned ANGLE_W  = 32;
  localparam int unsigned POWER_W  = 16;
  localparam int unsigned PERIOD_W = 17;
  localparam int unsigned HALF_W   = PERIOD_W - 1;

  // config port
  localparam int unsigned REG_INDEX_W = 2;
  localparam logic [REG_INDEX_W-1:0] REG_TIMER_PERIOD = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_DRIVE_ENABLE = 2'd1;
  localparam logic [PERIOD_W-1:0]    PERIOD_RESET     = 17'd3600;

  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  // power limiting, 1/256 percent units
  localparam int unsigned POWER_CAP      = 15360;
  localparam int unsigned POWER_FALLBACK = 10240;
  localparam int unsigned POWER_DIVISOR  = 25600;
  localparam int unsigned P_W            = $clog2(POWER_CAP + 1);

  // amplitude = floor(half * p / POWER_DIVISOR) via reciprocal plus one fixup
  localparam int unsigned AMP_PROD_W = HALF_W + P_W;
  localparam longint unsigned RECIP_P = (64'd1 << AMP_PROD_W) / POWER_DIVISOR;
  localparam int unsigned RP_W       = $clog2(RECIP_P + 1);
  localparam int unsigned AMP_W      = HALF_W;

  // offset = trunc(sine * amp / SINE_SCALE) on magnitudes
  localparam int unsigned MAG_W   = (SINE_W - 1) + AMP_W;
  localparam longint unsigned RECIP_S = (64'd1 << MAG_W) / SINE_SCALE;
  localparam int unsigned RS_W    = $clog2(RECIP_S + 1);
  localparam int unsigned CMP_W   = AMP_W + 3;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic signed [SINE_W-1:0] sine_t;
  typedef sine_t [TABLE_ENTRIES-1:0] sine_table_t;

  // Q30 series constants
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned HORNER_DIVS [6] = '{156, 110, 72, 42, 20, 6};

  // one table entry, quadrant folded, Horner series to the y^13 term
  function automatic sine_t sine_entry(int unsigned i);
    longint unsigned q;
    longint unsigned r;
    longint unsigned y;
    longint unsigned y2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned mag;
    sine_t           res;
    q = (64'(i) * 64'd4) / TABLE_ENTRIES;
    r = 64'(i) * 64'd4 - q * TABLE_ENTRIES;
    if (q[0]) begin
      r = TABLE_ENTRIES - r;
    end
    if (r == 0) begin
      mag = 0;
    end else if (r == TABLE_ENTRIES) begin
      mag = SINE_SCALE;
    end else begin
      y  = (HALF_PI_Q30 * r) / TABLE_ENTRIES;
      y2 = (y * y) >> 30;
      t  = Q30_ONE;
      for (int k = 0; k < 6; k++) begin
        t = Q30_ONE - ((y2 * t) >> 30) / HORNER_DIVS[k];
      end
      s = (y * t) >> 30;
      if (s > Q30_ONE) begin
        s = Q30_ONE;
      end
      mag = (s * SINE_SCALE) >> 30;
    end
    res = SINE_W'(mag);
    if (q >= 2) begin
      res = -res;
    end
    return res;
  endfunction

  function automatic sine_table_t build_sine_table();
    sine_table_t tbl;
    for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
      tbl[i] = sine_entry(i);
    end
    return tbl;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

/* hw/rtl/stpc_sine_rom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpc_sine_rom: one read port on the sine table
// Registered read; the data register holds while en is low.
// ----------------------------------------------------------------------------
module stpc_sine_rom (
  input  logic          clk,
  input  logic          en,
  input  stpc_pkg::idx_t  addr,
  output stpc_pkg::sine_t data
);
  import stpc_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      data <= SINE_TABLE[addr];
    end
  end

endmodule

/* hw/rtl/sine_three_phase_pwm_compare_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_three_phase_pwm_compare_unit: sinusoidal three-phase compare generator
// Turns axis, electrical angle and drive power into three PWM compare values.
// ----------------------------------------------------------------------------
// Seven-stage pipeline: a word passes through every stage register in turn
// before it shows on the output; with out_ready held high one word enters
// and one leaves every cycle. Each stage holds its word while the next
// one cannot take it, so bubbles
// are squeezed out under back-pressure. The sine table (360 entries) sits in
// three single-port ROM copies read in stage two; it needs no clearing pass.
// Words with drive_enable low or axis 3 are taken and dropped. Write
// timer_period and drive_enable only while the pipeline is empty.
module sine_three_phase_pwm_compare_unit (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             write_enable,
  input  logic [stpc_pkg::REG_INDEX_W-1:0] write_index,
  input  logic [stpc_pkg::PERIOD_W-1:0]    write_data,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [stpc_pkg::AXIS_W-1:0]      axis,
  input  logic signed [stpc_pkg::ANGLE_W-1:0] electrical_angle,
  input  logic signed [stpc_pkg::POWER_W-1:0] drive_power,
  // output channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [stpc_pkg::AXIS_W-1:0]      motor_axis,
  output logic [stpc_pkg::PERIOD_W-1:0]    phase_a_compare,
  output logic [stpc_pkg::PERIOD_W-1:0]    phase_b_compare,
  output logic [stpc_pkg::PERIOD_W-1:0]    phase_c_compare
);
  import stpc_pkg::*;

  localparam int unsigned NUM_STAGES = 7;
  localparam int unsigned IDX_PROD_W = 16 + IDX_W;

  // config registers
  logic [PERIOD_W-1:0] timer_period;
  logic                drive_enable;
  logic [HALF_W-1:0]   half;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_period <= PERIOD_RESET;
      drive_enable <= 1'b0;
    end else if (write_enable) begin
      case (write_index)
        REG_TIMER_PERIOD: timer_period <= write_data;
        REG_DRIVE_ENABLE: drive_enable <= write_data[0];
        default: ;
      endcase
    end
  end

  assign half = timer_period[PERIOD_W-1:1];

  // pipeline flow control
  logic [NUM_STAGES:1] vld;
  logic [NUM_STAGES:1] load;
  logic                in_take;

  always_comb begin
    load[NUM_STAGES] = !vld[NUM_STAGES] || out_ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  assign in_ready = load[1];
  assign in_take  = in_valid && drive_enable && (axis != AXIS_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[1]) begin
        vld[1] <= in_take;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (load[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: table index, power limit
  logic [IDX_PROD_W-1:0] idx_prod;
  logic [P_W-1:0]        power_lim;
  logic [AXIS_W-1:0]     s1_axis;
  idx_t                  s1_idx;
  logic [P_W-1:0]        s1_power;

  assign idx_prod = IDX_PROD_W'(electrical_angle[15:0]) * IDX_PROD_W'(TABLE_ENTRIES);

  always_comb begin
    if (drive_power[POWER_W-1]) begin
      power_lim = '0;
    end else if (drive_power > POWER_W'(POWER_CAP)) begin
      power_lim = P_W'(POWER_FALLBACK);
    end else begin
      power_lim = drive_power[P_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s1_axis  <= axis;
      s1_idx   <= idx_prod[IDX_PROD_W-1:16];
      s1_power <= power_lim;
    end
  end

  // stage 2: three ROM reads, half * power
  logic [IDX_W:0]        idx_b_sum;
  logic [IDX_W:0]        idx_c_sum;
  idx_t                  rd_addr [3];
  sine_t                 s2_sine [3];
  logic [AXIS_W-1:0]     s2_axis;
  logic [AMP_PROD_W-1:0] s2_amp_prod;

  always_comb begin
    idx_b_sum = {1'b0, s1_idx} + (IDX_W + 1)'(PHASE_STEP);
    idx_c_sum = {1'b0, s1_idx} + (IDX_W + 1)'(2 * PHASE_STEP);
    if (idx_b_sum >= (IDX_W + 1)'(TABLE_ENTRIES)) begin
      idx_b_sum = idx_b_sum - (IDX_W + 1)'(TABLE_ENTRIES);
    end
    if (idx_c_sum >= (IDX_W + 1)'(TABLE_ENTRIES)) begin
      idx_c_sum = idx_c_sum - (IDX_W + 1)'(TABLE_ENTRIES);
    end
    rd_addr[0] = s1_idx;
    rd_addr[1] = idx_b_sum[IDX_W-1:0];
    rd_addr[2] = idx_c_sum[IDX_W-1:0];
  end

  for (genvar g = 0; g < 3; g++) begin : g_rom
    stpc_sine_rom u_rom (
      .clk  (clk),
      .en   (load[2]),
      .addr (rd_addr[g]),
      .data (s2_sine[g])
    );
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      s2_axis     <= s1_axis;
      s2_amp_prod <= AMP_PROD_W'(half) * AMP_PROD_W'(s1_power);
    end
  end

  // stage 3: amplitude estimate by reciprocal
  logic [AMP_PROD_W+RP_W-1:0] amp_est_full;
  logic [AXIS_W-1:0]          s3_axis;
  logic [AMP_PROD_W-1:0]      s3_amp_prod;
  logic [AMP_W-1:0]           s3_amp_est;
  sine_t                      s3_sine [3];

  assign amp_est_full = (AMP_PROD_W + RP_W)'(s2_amp_prod)
                      * (AMP_PROD_W + RP_W)'(RECIP_P);

  always_ff @(posedge clk) begin
    if (load[3]) begin
      s3_axis     <= s2_axis;
      s3_amp_prod <= s2_amp_prod;
      s3_amp_est  <= amp_est_full[AMP_PROD_W +: AMP_W];
      s3_sine     <= s2_sine;
    end
  end

  // stage 4: estimate is low by at most one
  logic [AMP_PROD_W-1:0] amp_rem;
  logic [AMP_W-1:0]      amp_fixed;
  logic [AXIS_W-1:0]     s4_axis;
  logic [AMP_W-1:0]      s4_amp;
  sine_t                 s4_sine [3];

  always_comb begin
    amp_rem   = s3_amp_prod - AMP_PROD_W'(s3_amp_est) * AMP_PROD_W'(POWER_DIVISOR);
    amp_fixed = s3_amp_est;
    if (amp_rem >= AMP_PROD_W'(POWER_DIVISOR)) begin
      amp_fixed = s3_amp_est + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load[4]) begin
      s4_axis <= s3_axis;
      s4_amp  <= amp_fixed;
      s4_sine <= s3_sine;
    end
  end

  // stage 5: |sine| * amplitude per phase
  logic [SINE_W-2:0]  sine_abs [3];
  logic [AXIS_W-1:0]  s5_axis;
  logic [MAG_W-1:0]   s5_mag [3];
  logic [2:0]         s5_neg;

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      if (s4_sine[p][SINE_W-1]) begin
        sine_abs[p] = (SINE_W - 1)'(-s4_sine[p]);
      end else begin
        sine_abs[p] = s4_sine[p][SINE_W-2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[5]) begin
      s5_axis <= s4_axis;
      for (int p = 0; p < 3; p++) begin
        s5_mag[p] <= MAG_W'(sine_abs[p]) * MAG_W'(s4_amp);
        s5_neg[p] <= s4_sine[p][SINE_W-1];
      end
    end
  end

  // stage 6: offset estimate by reciprocal
  logic [MAG_W+RS_W-1:0] off_est_full [3];
  logic [AXIS_W-1:0]     s6_axis;
  logic [MAG_W-1:0]      s6_mag [3];
  logic [2:0]            s6_neg;
  logic [AMP_W-1:0]      s6_off_est [3];

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      off_est_full[p] = (MAG_W + RS_W)'(s5_mag[p]) * (MAG_W + RS_W)'(RECIP_S);
    end
  end

  always_ff @(posedge clk) begin
    if (load[6]) begin
      s6_axis <= s5_axis;
      s6_mag  <= s5_mag;
      s6_neg  <= s5_neg;
      for (int p = 0; p < 3; p++) begin
        s6_off_est[p] <= off_est_full[p][MAG_W +: AMP_W];
      end
    end
  end

  // stage 7: fix offset, apply sign, clamp to 0..period
  logic [MAG_W-1:0]        off_rem [3];
  logic [AMP_W-1:0]        off_fixed [3];
  logic signed [CMP_W-1:0] cmp_raw [3];
  logic [PERIOD_W-1:0]     cmp_clamped [3];

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      off_rem[p]   = s6_mag[p] - MAG_W'(s6_off_est[p]) * MAG_W'(SINE_SCALE);
      off_fixed[p] = s6_off_est[p];
      if (off_rem[p] >= MAG_W'(SINE_SCALE)) begin
        off_fixed[p] = s6_off_est[p] + 1'b1;
      end
      if (s6_neg[p]) begin
        cmp_raw[p] = $signed(CMP_W'(half)) - $signed(CMP_W'(off_fixed[p]));
      end else begin
        cmp_raw[p] = $signed(CMP_W'(half)) + $signed(CMP_W'(off_fixed[p]));
      end
      if (cmp_raw[p] < 0) begin
        cmp_clamped[p] = '0;
      end else if (cmp_raw[p] > $signed(CMP_W'(timer_period))) begin
        cmp_clamped[p] = timer_period;
      end else begin
        cmp_clamped[p] = cmp_raw[p][PERIOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[7]) begin
      motor_axis      <= s6_axis;
      phase_a_compare <= cmp_clamped[0];
      phase_b_compare <= cmp_clamped[1];
      phase_c_compare <= cmp_clamped[2];
    end
  end

  assign out_valid = vld[NUM_STAGES];

  // checks
  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (phase_a_compare <= timer_period) && (phase_b_compare <= timer_period)
                  && (phase_c_compare <= timer_period))
    else $error("compare value above timer period");

  a_drop_unused: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (!drive_enable || axis == AXIS_NONE) |=> !vld[1])
    else $error("dropped word entered pipeline");

  a_axis_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> motor_axis != AXIS_NONE)
    else $error("result for unknown axis");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    vld[4] && !load[5] |=> vld[4] && $stable(s4_amp))
    else $error("stalled stage lost its word");

endmodule

/* tb/tb_sine_three_phase_pwm_compare_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the three-phase sinusoidal PWM compare unit
// Drives axis, angle and power words through the valid/ready input, predicts
// the three phase compares of each word from an independently built sine
// table and the current period, and checks every output word in order.
// Covers power limiting, unknown axis, disabled drive, odd periods, random
// stalls on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_sine_three_phase_pwm_compare_unit;
  import stpc_pkg::*;

  typedef struct packed {
    logic [AXIS_W-1:0]   axis;
    logic [PERIOD_W-1:0] cmp_a;
    logic [PERIOD_W-1:0] cmp_b;
    logic [PERIOD_W-1:0] cmp_c;
  } compare_word_t;

  localparam longint unsigned ONE_Q30          = 64'd1 << 30;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

  logic                        clk;
  logic                        rst;
  logic                        write_enable;
  logic [REG_INDEX_W-1:0]      write_index;
  logic [PERIOD_W-1:0]         write_data;
  logic                        in_valid;
  logic                        in_ready;
  logic [AXIS_W-1:0]           axis;
  logic signed [ANGLE_W-1:0]   electrical_angle;
  logic signed [POWER_W-1:0]   drive_power;
  logic                        out_valid;
  logic                        out_ready;
  logic [AXIS_W-1:0]           motor_axis;
  logic [PERIOD_W-1:0]         phase_a_compare;
  logic [PERIOD_W-1:0]         phase_b_compare;
  logic [PERIOD_W-1:0]         phase_c_compare;

  // predictor state
  sine_t               sine_lut [TABLE_ENTRIES];
  logic [PERIOD_W-1:0] cfg_period;
  logic                cfg_enable;
  compare_word_t       pending_compares [$];
  compare_word_t       head_word;
  int                  mismatch_count;

  // traffic shaping
  int                  send_idle_pct;
  int                  stall_pct;
  bit                  hold_req;
  int                  hold_len;

  sine_three_phase_pwm_compare_unit dut (
    .clk              (clk),
    .rst              (rst),
    .write_enable     (write_enable),
    .write_index      (write_index),
    .write_data       (write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .axis             (axis),
    .electrical_angle (electrical_angle),
    .drive_power      (drive_power),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .motor_axis       (motor_axis),
    .phase_a_compare  (phase_a_compare),
    .phase_b_compare  (phase_b_compare),
    .phase_c_compare  (phase_c_compare)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // sine of i/TABLE_ENTRIES turn, quadrant folded, Q30 series to y^13
  function automatic sine_t folded_sine(int unsigned i);
    longint unsigned quad;
    longint unsigned rem;
    longint unsigned y;
    longint unsigned y_sq;
    longint unsigned acc;
    longint unsigned s;
    longint unsigned mag;
    longint unsigned series_div [6];
    sine_t           val;
    series_div = '{156, 110, 72, 42, 20, 6};
    quad = (longint'(i) * 4) / TABLE_ENTRIES;
    rem  = longint'(i) * 4 - quad * TABLE_ENTRIES;
    if (quad[0]) begin
      rem = TABLE_ENTRIES - rem;
    end
    if (rem == 0) begin
      mag = 0;
    end else if (rem == TABLE_ENTRIES) begin
      mag = SINE_SCALE;
    end else begin
      y    = (QUARTER_TURN_Q30 * rem) / TABLE_ENTRIES;
      y_sq = (y * y) >> 30;
      acc  = ONE_Q30;
      for (int k = 0; k < 6; k++) begin
        acc = ONE_Q30 - ((y_sq * acc) >> 30) / series_div[k];
      end
      s = (y * acc) >> 30;
      if (s > ONE_Q30) begin
        s = ONE_Q30;
      end
      mag = (s * SINE_SCALE) >> 30;
    end
    val = sine_t'(mag);
    if (quad >= 2) begin
      val = -val;
    end
    return val;
  endfunction

  function automatic logic [PERIOD_W-1:0] phase_value(sine_t s, longint amp, longint half,
                                                        longint period);
    longint prod;
    longint c;
    prod = longint'(s) * amp;
    // signed division truncates toward zero
    c = half + prod / longint'(SINE_SCALE);
    if (c > period) begin
      c = period;
    end
    if (c < 0) begin
      c = 0;
    end
    return c[PERIOD_W-1:0];
  endfunction

  function automatic compare_word_t compute_compares(logic [AXIS_W-1:0] ax,
                                                    logic [ANGLE_W-1:0] ang,
                                                    logic [POWER_W-1:0] pw);
    compare_word_t   w;
    longint unsigned p;
    longint unsigned idx;
    longint unsigned half;
    longint unsigned amp;
    if (pw[POWER_W-1]) begin
      p = 0;
    end else if (pw > POWER_CAP) begin
      p = POWER_FALLBACK;
    end else begin
      p = pw;
    end
    idx = (longint'(ang[15:0]) * TABLE_ENTRIES) >> 16;
    if (idx >= TABLE_ENTRIES) begin
      idx = 0;
    end
    half = cfg_period >> 1;
    amp  = (half * p) / POWER_DIVISOR;
    w.axis  = ax;
    w.cmp_a = phase_value(sine_lut[idx], amp, half, cfg_period);
    w.cmp_b = phase_value(sine_lut[(idx + PHASE_STEP) % TABLE_ENTRIES], amp, half, cfg_period);
    w.cmp_c = phase_value(sine_lut[(idx + 2 * PHASE_STEP) % TABLE_ENTRIES], amp, half,
                          cfg_period);
    return w;
  endfunction

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    $display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
    mismatch_count++;
  endtask

  // output checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_compares.size() == 0) begin
        report_mismatch("unexpected word, axis", -1, motor_axis);
      end else begin
        head_word = pending_compares.pop_front();
        if (motor_axis !== head_word.axis) begin
          report_mismatch("motor_axis", head_word.axis, motor_axis);
        end
        if (phase_a_compare !== head_word.cmp_a) begin
          report_mismatch("phase_a_compare", head_word.cmp_a, phase_a_compare);
        end
        if (phase_b_compare !== head_word.cmp_b) begin
          report_mismatch("phase_b_compare", head_word.cmp_b, phase_b_compare);
        end
        if (phase_c_compare !== head_word.cmp_c) begin
          report_mismatch("phase_c_compare", head_word.cmp_c, phase_c_compare);
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_word(logic [AXIS_W-1:0] ax, logic [ANGLE_W-1:0] ang,
                           logic [POWER_W-1:0] pw);
    // each idle cycle is taken with send_idle_pct percent odds
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid         <= 1'b1;
    axis             <= ax;
    electrical_angle <= ang;
    drive_power      <= pw;
    do @(posedge clk); while (!in_ready);
    if (cfg_enable && ax != AXIS_NONE) begin
      pending_compares.push_back(compute_compares(ax, ang, pw));
    end
  endtask

  // stop offering, wait for every expected word, then let dropped words clear
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_compares.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_INDEX_W-1:0] idx, logic [PERIOD_W-1:0] data);
    @(posedge clk);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= data;
    @(posedge clk);
    write_enable <= 1'b0;
    if (idx == REG_TIMER_PERIOD) begin
      cfg_period = data;
    end else if (idx == REG_DRIVE_ENABLE) begin
      cfg_enable = data[0];
    end
  endtask

  task automatic set_drive(logic [PERIOD_W-1:0] period, logic en);
    write_reg(REG_TIMER_PERIOD, period);
    write_reg(REG_DRIVE_ENABLE, {{(PERIOD_W-1){1'b0}}, en});
  endtask

  function automatic logic [POWER_W-1:0] random_power();
    case ($urandom_range(5))
      0: return POWER_W'($urandom());
      1: return POWER_W'($urandom_range(POWER_CAP));
      2: return POWER_W'($urandom_range(POWER_CAP - 5, POWER_CAP + 5));
      3: return {1'b1, 15'($urandom())};
      4: return POWER_W'($urandom_range(255));
      default: return POWER_W'(POWER_CAP);
    endcase
  endfunction

  function automatic logic [ANGLE_W-1:0] random_angle();
    int unsigned k;
    logic [15:0] edge_pos;
    if ($urandom_range(3) != 0) begin
      return $urandom();
    end
    // land on or beside a table index boundary
    k = $urandom_range(TABLE_ENTRIES - 1);
    edge_pos = 16'((k * 65536 + TABLE_ENTRIES - 1) / TABLE_ENTRIES + $urandom_range(2) - 1);
    return {16'($urandom()), edge_pos};
  endfunction

  task automatic run_segment(logic [PERIOD_W-1:0] period, logic en, int count);
    set_drive(period, en);
    for (int n = 0; n < count; n++) begin
      send_word(AXIS_W'($urandom_range(3)), random_angle(), random_power());
      if ($urandom_range(99) == 0) begin
        // sender waits out the whole pipeline now and then
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_compares.size() != 0) @(posedge clk);
      end
    end
    drain_pipeline();
  endtask

  task automatic test_corner_words();
    set_drive(PERIOD_RESET, 1'b1);
    send_word(2'd0, 32'h0000_0000, 16'sd0);
    send_word(2'd1, 32'h0000_4000, 16'sd15360);
    send_word(2'd2, 32'h0000_8000, 16'sd15361);
    send_word(2'd0, 32'h0000_C000, 16'sd32767);
    send_word(2'd1, 32'h0000_FFFF, -16'sd1);
    send_word(2'd2, 32'h7FFF_FFFF, -16'sd32768);
    send_word(2'd0, 32'h8000_0000, 16'sd25600);
    send_word(2'd1, 32'hFFFF_0000, 16'sd10240);
    send_word(AXIS_NONE, 32'h0000_1234, 16'sd5000);
    send_word(2'd2, 32'hFFFF_FFFF, 16'sd1);
    send_word(2'd0, 32'd182, 16'sd15360);
    send_word(2'd1, 32'd183, 16'sd15360);
    send_word(2'd2, 32'h5555_5555, 16'sd12800);
    send_word(2'd0, 32'hAAAA_AAAA, 16'sd15360);
    drain_pipeline();
  endtask

  task automatic test_period_corners();
    logic [PERIOD_W-1:0] periods [5];
    periods = '{17'd65536, 17'h1FFFF, 17'd0, 17'd1, 17'd2};
    foreach (periods[i]) begin
      set_drive(periods[i], 1'b1);
      send_word(2'd1, 32'h0000_4000, 16'sd15360);
      send_word(2'd2, 32'h0000_C000, 16'sd15360);
      drain_pipeline();
    end
  endtask

  task automatic test_disabled();
    set_drive(PERIOD_RESET, 1'b0);
    send_word(2'd0, 32'h0000_4000, 16'sd15360);
    send_word(2'd1, 32'h1234_5678, 16'sd100);
    send_word(2'd2, 32'hFFFF_C000, -16'sd1);
    send_word(AXIS_NONE, 32'h0, 16'sd0);
    drain_pipeline();
    write_reg(REG_DRIVE_ENABLE, {{(PERIOD_W-1){1'b0}}, 1'b1});
  endtask

  // hold the output long enough that the pipeline fills and stalls the input
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    set_drive(17'd40000, 1'b1);
    hold_len = 300;
    hold_req = 1'b1;
    for (int n = 0; n < 40; n++) begin
      send_word(AXIS_W'($urandom_range(2)), random_angle(), random_power());
    end
    drain_pipeline();
  endtask

  task automatic test_random_traffic(int idle_pct, int ready_stall_pct);
    send_idle_pct = idle_pct;
    stall_pct     = ready_stall_pct;
    run_segment(PERIOD_W'($urandom_range(2, 65536)), 1'b1, 120);
    run_segment(17'd2, 1'b1, 50);
    run_segment(17'd65536, 1'b1, 80);
    run_segment(17'h1FFFF, 1'b1, 30);
    run_segment(PERIOD_W'($urandom_range(1)), 1'b1, 20);
    run_segment(PERIOD_W'($urandom()), 1'b0, 20);
    run_segment(PERIOD_RESET, 1'b1, 90);
  endtask

  initial begin
    rst              <= 1'b1;
    write_enable     <= 1'b0;
    write_index      <= REG_TIMER_PERIOD;
    write_data       <= '0;
    in_valid         <= 1'b0;
    axis             <= '0;
    electrical_angle <= '0;
    drive_power      <= '0;
    cfg_period     = PERIOD_RESET;
    cfg_enable     = 1'b0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_req       = 1'b0;
    hold_len       = 0;
    for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
      sine_lut[i] = folded_sine(i);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_corner_words();
    test_period_corners();
    test_disabled();
    test_backpressure();
    test_random_traffic(25, 72);
    test_random_traffic(72, 25);
    test_random_traffic(0, 0);

    drain_pipeline();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
